// ===== rtl/ccpd_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and the crc byte update for the packet deframer
// no dependencies

package ccpd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_HDR = 2'd1;
  localparam logic [1:0] STATUS_LEN = 2'd2;
  localparam logic [1:0] STATUS_CRC = 2'd3;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [8:0]  MIN_FRAME = 9'd6;
  localparam logic [7:0]  POS_MAX   = 8'hFF;
  localparam logic [7:0]  POS_ID    = 8'd1;
  localparam logic [7:0]  POS_OP    = 8'd2;
  localparam logic [7:0]  POS_LEN   = 8'd3;
  localparam logic [7:0]  POS_PAY   = 8'd4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } rx_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [1:0] status;
    logic [7:0] frame_id;
    logic [7:0] opcode;
    logic [7:0] payload_length;
  } res_t;

  // classified word handed from front to back
  typedef struct packed {
    res_t       res;
    logic       check_crc;
    logic       feed;
    logic [7:0] feed_byte;
    logic [7:0] held_hi;
    logic [7:0] last_lo;
  } cls_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ccpd_front.sv =====
`timescale 1ns / 1ps
// front end: byte position, header capture, payload marking, marker and length checks
// depends on ccpd_pkg

module ccpd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       start_marker,
  input  logic             rx_valid,
  output logic             rx_ready,
  input  ccpd_pkg::rx_t    rx_data,
  output logic             push_valid,
  input  logic             push_ready,
  output ccpd_pkg::cls_t   push_data
);
  import ccpd_pkg::*;

  logic [7:0] pos;
  logic       marker_ok;
  logic [7:0] id_reg;
  logic [7:0] op_reg;
  logic [7:0] len_reg;
  logic [7:0] held_lo;
  logic [7:0] held_hi;

  logic       marker_now;
  logic [7:0] id_now;
  logic [7:0] op_now;
  logic [7:0] len_now;
  logic       pay;
  logic [8:0] frame_len;
  logic       last;
  logic [7:0] b;
  logic       accept;

  assign b          = rx_data.byte_in;
  assign last       = rx_data.last_byte;
  assign rx_ready   = push_ready;
  assign push_valid = rx_valid;
  assign accept     = rx_valid && push_ready;

  always_comb begin
    marker_now = (pos == 8'd0)    ? (b == start_marker) : marker_ok;
    id_now     = (pos == POS_ID)  ? b : id_reg;
    op_now     = (pos == POS_OP)  ? b : op_reg;
    len_now    = (pos == POS_LEN) ? b : len_reg;
    // saturated position means 255 or later, never payload
    pay        = (pos >= POS_PAY) && (pos != POS_MAX) &&
                 ({1'b0, pos} < ({1'b0, POS_PAY} + {1'b0, len_now}));
    frame_len  = {1'b0, pos} + 9'd1;

    push_data                    = '0;
    push_data.res.payload_valid  = pay;
    push_data.res.payload_byte   = pay ? b : 8'h00;
    push_data.res.frame_done     = last;
    push_data.feed               = (pos >= POS_OP);
    push_data.feed_byte          = held_lo;
    push_data.held_hi            = held_hi;
    push_data.last_lo            = b;
    if (last) begin
      push_data.res.frame_id       = id_now;
      push_data.res.opcode         = op_now;
      push_data.res.payload_length = len_now;
      priority if (frame_len < MIN_FRAME || !marker_now) begin
        push_data.res.status = STATUS_HDR;
      end else if (len_now == 8'd0 || frame_len < ({1'b0, len_now} + MIN_FRAME)) begin
        push_data.res.status = STATUS_LEN;
      end else begin
        push_data.res.status = STATUS_OK;
        push_data.check_crc  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      marker_ok <= 1'b0;
      id_reg    <= '0;
      op_reg    <= '0;
      len_reg   <= '0;
      held_lo   <= '0;
      held_hi   <= '0;
    end else if (accept) begin
      if (last) begin
        pos       <= '0;
        marker_ok <= 1'b0;
        id_reg    <= '0;
        op_reg    <= '0;
        len_reg   <= '0;
        held_lo   <= '0;
        held_hi   <= '0;
      end else begin
        pos       <= (pos == POS_MAX) ? pos : pos + 8'd1;
        marker_ok <= marker_now;
        id_reg    <= id_now;
        op_reg    <= op_now;
        len_reg   <= len_now;
        held_lo   <= held_hi;
        held_hi   <= b;
      end
    end
  end

endmodule

// ===== rtl/ccpd_queue.sv =====
`timescale 1ns / 1ps
// short fifo between the front and back ends
// depends on ccpd_pkg

module ccpd_queue #(
  parameter int DEPTH = ccpd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ccpd_pkg::cls_t   push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ccpd_pkg::cls_t   pop_data
);
  import ccpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cls_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ccpd_back.sv =====
`timescale 1ns / 1ps
// back end: crc accumulation, crc compare on the last byte, result register
// depends on ccpd_pkg

module ccpd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  ccpd_pkg::cls_t   pop_data,
  output logic             res_valid,
  input  logic             res_ready,
  output ccpd_pkg::res_t   res_data
);
  import ccpd_pkg::*;

  logic [15:0] crc;
  logic [15:0] crc_cur;
  logic        crc_bad;
  logic        take;
  res_t        res_next;

  assign pop_ready = !res_valid || res_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    // the byte two places back is known not to be a crc byte
    crc_cur  = pop_data.feed ? crc_feed(crc, pop_data.feed_byte) : crc;
    crc_bad  = (crc_cur != {pop_data.held_hi, pop_data.last_lo});
    res_next = pop_data.res;
    if (pop_data.check_crc) begin
      res_next.status = crc_bad ? STATUS_CRC : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        crc       <= pop_data.res.frame_done ? CRC_INIT : crc_cur;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== rtl/crc_checked_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// top level of the crc checked packet deframer
// depends on ccpd_pkg, ccpd_front, ccpd_queue, ccpd_back

// Takes one received byte per cycle while the queue has room and gives one
// result word per byte via the queue and the result register: payload bytes
// are flagged as they pass, and the word for the byte marked last carries the
// frame status, id, opcode and length. Sustained rate is one byte per clock
// while res_ready stays high; the limit is the byte-wide crc-16/modbus update
// in the back end. A queue of DEPTH words lets the input keep flowing while a
// result waits on res_ready. The start marker register is always writable
// (cfg_ready is tied high) and is compared when byte 0 of a frame is accepted.
module crc_checked_packet_deframer_core #(
  parameter int DEPTH = ccpd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  input  logic             rx_valid,
  output logic             rx_ready,
  input  ccpd_pkg::rx_t    rx_data,
  output logic             res_valid,
  input  logic             res_ready,
  output ccpd_pkg::res_t   res_data
);
  import ccpd_pkg::*;

  logic [7:0] start_marker;
  logic       q_push_valid;
  logic       q_push_ready;
  cls_t       q_push_data;
  logic       q_valid;
  logic       q_ready;
  cls_t       q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_marker <= cfg_data;
    end
  end

  ccpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start_marker (start_marker),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_data      (rx_data),
    .push_valid   (q_push_valid),
    .push_ready   (q_push_ready),
    .push_data    (q_push_data)
  );

  ccpd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  ccpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

`ifndef SYNTHESIS
  // a full queue must hold something for the back end
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> q_valid)
    else $error("queue full but nothing to pop");

  // every word taken by the back end shows up in the result register
  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> res_valid)
    else $error("popped word did not reach the result register");

  // a last byte that is still payload means the frame was too short for its length
  a_last_payload_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.payload_valid && res_data.frame_done) |->
      (res_data.status == STATUS_LEN || res_data.status == STATUS_HDR))
    else $error("payload on last byte with a passing status");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench for crc_checked_packet_deframer_core: directed frames, then random
// frames, checked word by word against a built-in deframer model
// depends on ccpd_pkg and the rtl of the deframer

module tb;
  import ccpd_pkg::*;

  localparam int RAND_ITEMS  = 1600;
  localparam int NUM_PHASES  = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTS  = 50;
  localparam res_t NO_RES    = '0;

  typedef enum logic [1:0] {ROW_RAW, ROW_CRC_HI, ROW_CRC_LO} row_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    row_kind_t  kind;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  rx_t        rx_data = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  res_t       res_data;

  crc_checked_packet_deframer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_data   (rx_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // deframer model state
  logic [7:0]  m_marker = 8'h00;
  logic [15:0] m_crc = CRC_INIT;
  logic [7:0]  m_pos = 8'h00;
  logic [7:0]  m_held [2] = '{8'h00, 8'h00};
  logic        m_marker_ok = 1'b0;
  logic [7:0]  m_id = 8'h00;
  logic [7:0]  m_op = 8'h00;
  logic [7:0]  m_len = 8'h00;

  res_t       expected_words [$];
  dir_row_t   dir_rows [$];
  logic       pend_typed = 1'b0;
  res_t       pend_want = '0;
  logic       calm = 1'b0;
  logic [7:0] cur_marker = 8'h00;
  int         items_sent = 0;
  int         err_count = 0;
  int         quiet_cycles = 0;
  res_t       mon_got;
  res_t       mon_want;
  res_t       mon_pred;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if ((r[0] ^ b[k]) == 1'b1) begin
        r = {1'b0, r[15:1]} ^ 16'hA001;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  // advances the model by one received byte and gives the word it causes
  function automatic res_t deframe_byte(input rx_t w);
    res_t       r;
    logic       pay;
    logic [8:0] flen;
    r = '0;
    // a byte two places back can no longer be a crc byte
    if (m_pos >= 8'd2) m_crc = crc16_step(m_crc, m_held[0]);
    case (m_pos)
      8'd0: m_marker_ok = (w.byte_in == m_marker);
      POS_ID: m_id = w.byte_in;
      POS_OP: m_op = w.byte_in;
      POS_LEN: m_len = w.byte_in;
      default: ;
    endcase
    pay = (m_pos >= POS_PAY) && (m_pos != POS_MAX) &&
          ({1'b0, m_pos} < 9'd4 + {1'b0, m_len});
    r.payload_valid = pay;
    r.payload_byte = pay ? w.byte_in : 8'h00;
    r.frame_done = w.last_byte;
    if (w.last_byte) begin
      flen = {1'b0, m_pos} + 9'd1;
      if (flen < MIN_FRAME || !m_marker_ok) begin
        r.status = STATUS_HDR;
      end else if (m_len == 8'h00 || flen < {1'b0, m_len} + MIN_FRAME) begin
        r.status = STATUS_LEN;
      end else if (m_crc[15:8] != m_held[1] || m_crc[7:0] != w.byte_in) begin
        r.status = STATUS_CRC;
      end else begin
        r.status = STATUS_OK;
      end
      r.frame_id = m_id;
      r.opcode = m_op;
      r.payload_length = m_len;
      m_crc = CRC_INIT;
      m_pos = 8'h00;
      m_held = '{8'h00, 8'h00};
      m_marker_ok = 1'b0;
      m_id = 8'h00;
      m_op = 8'h00;
      m_len = 8'h00;
    end else begin
      m_held[0] = m_held[1];
      m_held[1] = w.byte_in;
      if (m_pos != POS_MAX) m_pos = m_pos + 8'd1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    end
    err_count++;
  endtask

  // prediction on accepted bytes, checking on accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_valid && rx_ready) begin
        mon_pred = deframe_byte(rx_data);
        expected_words.push_back(pend_typed ? pend_want : mon_pred);
      end
      // a marker written at this edge applies from the next byte on
      if (cfg_valid && cfg_ready) m_marker = cfg_data;
      if (res_valid && res_ready) begin
        mon_got = res_data;
        if (expected_words.size() == 0) begin
          flag_mismatch("word with none expected", mon_got.payload_byte, 8'h00);
        end else begin
          mon_want = expected_words.pop_front();
          if (mon_got.payload_valid !== mon_want.payload_valid)
            flag_mismatch("payload_valid", 8'(mon_got.payload_valid),
                          8'(mon_want.payload_valid));
          if (mon_got.payload_byte !== mon_want.payload_byte)
            flag_mismatch("payload_byte", mon_got.payload_byte, mon_want.payload_byte);
          if (mon_got.frame_done !== mon_want.frame_done)
            flag_mismatch("frame_done", 8'(mon_got.frame_done), 8'(mon_want.frame_done));
          if (mon_got.status !== mon_want.status)
            flag_mismatch("status", 8'(mon_got.status), 8'(mon_want.status));
          if (mon_got.frame_id !== mon_want.frame_id)
            flag_mismatch("frame_id", mon_got.frame_id, mon_want.frame_id);
          if (mon_got.opcode !== mon_want.opcode)
            flag_mismatch("opcode", mon_got.opcode, mon_want.opcode);
          if (mon_got.payload_length !== mon_want.payload_length)
            flag_mismatch("payload_length", mon_got.payload_length, mon_want.payload_length);
        end
      end
    end
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ready <= calm || ($urandom_range(99) >= 14);
  end

  // called and returning at a falling edge; valid stays up for a following word
  task automatic send_byte(input rx_t d, input logic typed, input res_t want);
    while (!calm && $urandom_range(99) < 14) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_data <= d;
    pend_typed = typed;
    pend_want = want;
    do @(posedge clk); while (!rx_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    rx_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_marker = v;
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input row_kind_t kind,
                         input logic typed, input res_t want);
    dir_rows.push_back('{b, last, kind, typed, want});
  endtask

  // one frame: mostly well formed, some with a bad crc, wrong marker,
  // zero length or cut short, a few words of noise, or with go_long the largest length
  task automatic send_frame(input logic go_long);
    logic [7:0]  fb [$];
    logic [15:0] c;
    logic        noise;
    int          pick;
    int          plen;
    int          ntrail;
    int          idx;
    pick = $urandom_range(99);
    noise = !go_long && pick >= 93;
    if (go_long) begin
      plen = 255;
      ntrail = $urandom_range(3, 12);
    end else begin
      plen = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      ntrail = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      if (pick >= 80 && pick < 86) plen = 0;
    end
    if (noise) begin
      repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom_range(255)));
    end else begin
      fb.push_back(cur_marker);
      fb.push_back(8'($urandom_range(255)));
      fb.push_back(8'($urandom_range(255)));
      fb.push_back(plen[7:0]);
      repeat (plen + ntrail) fb.push_back(8'($urandom_range(255)));
      c = CRC_INIT;
      foreach (fb[i]) c = crc16_step(c, fb[i]);
      fb.push_back(c[15:8]);
      fb.push_back(c[7:0]);
      if (!go_long) begin
        if (pick >= 55 && pick < 65) begin
          idx = $urandom_range(4, fb.size() - 1);
          fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
        end else if (pick >= 65 && pick < 72) begin
          fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
        end else if (pick >= 72 && pick < 80) begin
          idx = $urandom_range(1, fb.size() - 1);
          while (fb.size() > idx) void'(fb.pop_back());
        end
      end
    end
    foreach (fb[i]) begin
      send_byte('{byte_in: fb[i],
                  last_byte: (i == fb.size() - 1) || (noise && $urandom_range(2) == 0)},
                1'b0, NO_RES);
    end
  endtask

  initial begin
    logic [7:0]  b;
    logic [15:0] dcrc;
    logic [7:0]  mk;
    int          goal;

    // one byte frame: too short
    add_row(8'h00, 1'b1, ROW_RAW, 1'b1, '{1'b0, 8'h00, 1'b1, STATUS_HDR, 8'h00, 8'h00, 8'h00});
    // wrong start marker
    add_row(8'hFF, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h01, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h02, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h01, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h33, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h55, 1'b1, ROW_RAW, 1'b1, '{1'b0, 8'h00, 1'b1, STATUS_HDR, 8'h01, 8'h02, 8'h01});
    // zero payload length
    add_row(8'h00, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h10, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h20, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h00, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h00, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h00, 1'b1, ROW_RAW, 1'b1, '{1'b0, 8'h00, 1'b1, STATUS_LEN, 8'h10, 8'h20, 8'h00});
    // largest length, frame far too short; the last word still passes as payload
    add_row(8'h00, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h01, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h02, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'hFF, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'hAA, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'hBB, 1'b1, ROW_RAW, 1'b1, '{1'b1, 8'hBB, 1'b1, STATUS_LEN, 8'h01, 8'h02, 8'hFF});
    // good frame with its crc filled in as the rows are walked
    add_row(8'h00, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h5A, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h81, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h01, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'hFF, 1'b0, ROW_RAW, 1'b0, NO_RES);
    add_row(8'h00, 1'b0, ROW_CRC_HI, 1'b0, NO_RES);
    add_row(8'h00, 1'b1, ROW_CRC_LO, 1'b0, NO_RES);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_marker(8'h00);

    dcrc = CRC_INIT;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CRC_HI: b = dcrc[15:8];
        ROW_CRC_LO: b = dcrc[7:0];
        default: b = dir_rows[i].b;
      endcase
      send_byte('{byte_in: b, last_byte: dir_rows[i].last}, dir_rows[i].typed,
                dir_rows[i].want);
      if (dir_rows[i].kind == ROW_RAW) dcrc = crc16_step(dcrc, b);
      if (dir_rows[i].last) dcrc = CRC_INIT;
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      mk = (ph == 0) ? 8'hFF : (ph == 2) ? 8'h00 : 8'($urandom_range(255));
      write_marker(mk);
      // one phase runs with no stalls on either side
      calm = (ph == 2);
      goal = items_sent + RAND_ITEMS / NUM_PHASES;
      if (ph == 3) send_frame(1'b1);
      while (items_sent < goal) send_frame(1'b0);
    end
    calm = 1'b0;
    settle();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
